FILE: rtl/ata_pkg.sv
// ----------------------------------------------------------------------------
// ata_pkg: shared types, constants and angle table for the tilt angle core
// Item formats between front end, queue and back end, and the CORDIC angles.
// ----------------------------------------------------------------------------
package ata_pkg;

  localparam int DEFAULT_CORDIC_STEPS = 16;
  localparam int TABLE_LEN   = 24;
  localparam int SQ_W        = 48;   // radicand: (a^2+b^2) << 16
  localparam int ROOT_W      = 24;   // floor sqrt of radicand
  localparam int MAG_W       = 24;   // operand magnitude, 8 fraction bits
  localparam int CX_W        = 34;   // CORDIC x/y, signed, with growth
  localparam int ZW          = 28;   // angle accumulator, signed
  localparam int ANGLE_SHIFT = 16;
  localparam int RIGHT_ANGLE = 900;

  localparam logic [1:0] OP_ANGLE_Z = 2'd0;
  localparam logic [1:0] OP_ANGLE_X = 2'd1;
  localparam logic [1:0] OP_ANGLE_Y = 2'd2;

  typedef enum logic [2:0] {
    K_CORDIC,
    K_ZERO,
    K_DEGEN,
    K_POS90,
    K_NEG90
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        neg;          // numerator and denominator differ in sign
    logic        sqrt_is_num;  // square root gives the numerator
    logic [15:0] plain;        // magnitude of the plain axis
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [30:0] sq_a;
    logic [30:0] sq_b;
  } entry_t;

  // atan(2^-i) in units of 2^-16 tenth of a degree
  function automatic logic [25:0] atan_rom(input int idx);
    logic [25:0] v;
    case (idx)
      0:  v = 26'd29491200;
      1:  v = 26'd17409672;
      2:  v = 26'd9198793;
      3:  v = 26'd4669451;
      4:  v = 26'd2343786;
      5:  v = 26'd1173036;
      6:  v = 26'd586661;
      7:  v = 26'd293348;
      8:  v = 26'd146676;
      9:  v = 26'd73339;
      10: v = 26'd36669;
      11: v = 26'd18335;
      12: v = 26'd9167;
      13: v = 26'd4584;
      14: v = 26'd2292;
      15: v = 26'd1146;
      16: v = 26'd573;
      17: v = 26'd286;
      18: v = 26'd143;
      19: v = 26'd72;
      20: v = 26'd36;
      21: v = 26'd18;
      22: v = 26'd9;
      23: v = 26'd4;
      default: v = 26'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/accel_tilt_angle_core.sv
// ----------------------------------------------------------------------------
// accel_tilt_angle_core: tilt angle of a three-axis acceleration sample
// Start passes the front register, queue, sqrt and CORDIC pipelines and an output register before done.
// Throughput: one sample per cycle; the result pipeline never stalls since
// the receiver takes every result, so busy only rises if the queue fills.
// Reset: rst (synchronous) empties the front register, queue and pipeline.
// ----------------------------------------------------------------------------
module accel_tilt_angle_core #(
  parameter int CORDIC_STEPS = ata_pkg::DEFAULT_CORDIC_STEPS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [15:0]  accel_x,
  input  logic signed [15:0]  accel_y,
  input  logic signed [15:0]  accel_z,
  input  logic [1:0]          operation,
  output logic                done,
  output logic signed [10:0]  angle_tenths,
  output logic                degenerate
);
  import ata_pkg::*;

  // front end -> queue
  logic   fe_valid;
  entry_t fe_entry;
  logic   q_full;
  // queue -> back end
  logic   q_valid;
  entry_t q_entry;

  // Accept and classify the sample; hold it while the queue is full.
  ata_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .accel_x   (accel_x),
    .accel_y   (accel_y),
    .accel_z   (accel_z),
    .operation (operation),
    .out_valid (fe_valid),
    .out_entry (fe_entry),
    .out_full  (q_full)
  );

  // Decouple intake from the arithmetic pipeline.
  ata_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (fe_valid),
    .push_entry (fe_entry),
    .full       (q_full),
    .pop        (1'b1),
    .head_valid (q_valid),
    .head_entry (q_entry)
  );

  // Advance every queued word straight into the sqrt/CORDIC pipeline.
  ata_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (q_valid),
    .in_entry     (q_entry),
    .done         (done),
    .angle_tenths (angle_tenths),
    .degenerate   (degenerate)
  );

endmodule

FILE: rtl/ata_front.sv
// ----------------------------------------------------------------------------
// ata_front: sample intake and classification
// Picks numerator/denominator roles, flags special cases, squares the pair.
// ----------------------------------------------------------------------------
module ata_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [15:0]   accel_x,
  input  logic signed [15:0]   accel_y,
  input  logic signed [15:0]   accel_z,
  input  logic [1:0]           operation,
  output logic                 out_valid,
  output ata_pkg::entry_t      out_entry,
  input  logic                 out_full
);
  import ata_pkg::*;

  logic               valid;
  entry_t             entry;
  entry_t             entry_next;
  logic signed [15:0] sa;
  logic signed [15:0] sb;
  logic signed [15:0] sp;
  logic signed [16:0] sp_neg;
  logic signed [31:0] pa;
  logic signed [31:0] pb;

  assign busy      = valid && out_full;
  assign out_valid = valid;
  assign out_entry = entry;

  always_comb begin
    sa = accel_x;
    sb = accel_y;
    sp = accel_z;
    entry_next.side.kind        = K_ZERO;
    entry_next.side.neg         = 1'b0;
    entry_next.side.sqrt_is_num = 1'b1;
    case (operation)
      OP_ANGLE_Z: begin
        sa = accel_x;
        sb = accel_y;
        sp = accel_z;
        entry_next.side.sqrt_is_num = 1'b1;
        entry_next.side.neg         = accel_z < 0;
        if (accel_x == 0 && accel_y == 0)
          entry_next.side.kind = (accel_z == 0) ? K_DEGEN : K_ZERO;
        else if (accel_z == 0)
          entry_next.side.kind = K_POS90;
        else
          entry_next.side.kind = K_CORDIC;
      end
      OP_ANGLE_X: begin
        sa = accel_y;
        sb = accel_z;
        sp = accel_x;
        entry_next.side.sqrt_is_num = 1'b0;
        entry_next.side.neg         = accel_x < 0;
        if (accel_y == 0 && accel_z == 0)
          entry_next.side.kind = (accel_x == 0) ? K_DEGEN
                               : ((accel_x > 0) ? K_POS90 : K_NEG90);
        else if (accel_x == 0)
          entry_next.side.kind = K_ZERO;
        else
          entry_next.side.kind = K_CORDIC;
      end
      OP_ANGLE_Y: begin
        sa = accel_x;
        sb = accel_z;
        sp = accel_y;
        entry_next.side.sqrt_is_num = 1'b0;
        entry_next.side.neg         = accel_y < 0;
        if (accel_x == 0 && accel_z == 0)
          entry_next.side.kind = (accel_y == 0) ? K_DEGEN
                               : ((accel_y > 0) ? K_POS90 : K_NEG90);
        else if (accel_y == 0)
          entry_next.side.kind = K_ZERO;
        else
          entry_next.side.kind = K_CORDIC;
      end
      default: begin
        entry_next.side.kind = K_ZERO;
      end
    endcase
    sp_neg = -{sp[15], sp};
    entry_next.side.plain = sp[15] ? sp_neg[15:0] : sp;
    pa = sa * sa;
    pb = sb * sb;
    entry_next.sq_a = pa[30:0];
    entry_next.sq_b = pb[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (start && !busy) begin
      valid <= 1'b1;
    end else if (!out_full) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      entry <= entry_next;
    end
  end

endmodule

FILE: rtl/ata_queue.sv
// ----------------------------------------------------------------------------
// ata_queue: two-entry queue between front end and back end
// Push when not full, pop when the back end takes the head.
// ----------------------------------------------------------------------------
module ata_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ata_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output ata_pkg::entry_t head_entry
);
  import ata_pkg::*;

  entry_t     slots [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head_entry = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

FILE: rtl/ata_back.sv
// ----------------------------------------------------------------------------
// ata_back: square root and CORDIC pipeline
// One root bit per stage, then one CORDIC rotation per stage.
// ----------------------------------------------------------------------------
module ata_back #(
  parameter int CORDIC_STEPS = ata_pkg::DEFAULT_CORDIC_STEPS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  ata_pkg::entry_t     in_entry,
  output logic                done,
  output logic signed [10:0]  angle_tenths,
  output logic                degenerate
);
  import ata_pkg::*;

  localparam logic signed [ZW-1:0] Z_MAX = ZW'(RIGHT_ANGLE) <<< ANGLE_SHIFT;

  // square root pipeline
  logic              sq_valid [0:ROOT_W];
  side_t             sq_side  [0:ROOT_W];
  logic [SQ_W-1:0]   sq_rem   [0:ROOT_W];
  logic [ROOT_W-1:0] sq_root  [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else begin
      sq_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    sq_side[0] <= in_entry.side;
    sq_rem[0]  <= {32'({1'b0, in_entry.sq_a} + {1'b0, in_entry.sq_b}), 16'd0};
    sq_root[0] <= '0;
  end

  for (genvar s = 0; s < ROOT_W; s++) begin : g_sqrt
    localparam int K = ROOT_W - 1 - s;
    logic [SQ_W+1:0] cand;
    logic [SQ_W+1:0] rem_ext;
    assign cand    = ((SQ_W+2)'(sq_root[s]) << (K + 1)) + ((SQ_W+2)'(1) << (2 * K));
    assign rem_ext = (SQ_W+2)'(sq_rem[s]);

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[s+1] <= 1'b0;
      end else begin
        sq_valid[s+1] <= sq_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      sq_side[s+1] <= sq_side[s];
      if (rem_ext >= cand) begin
        sq_rem[s+1]  <= SQ_W'(rem_ext - cand);
        sq_root[s+1] <= sq_root[s] | (ROOT_W'(1) << K);
      end else begin
        sq_rem[s+1]  <= sq_rem[s];
        sq_root[s+1] <= sq_root[s];
      end
    end
  end

  // CORDIC pipeline, vectoring mode
  logic                   cv    [0:CORDIC_STEPS];
  side_t                  cside [0:CORDIC_STEPS];
  logic signed [CX_W-1:0] cx    [0:CORDIC_STEPS];
  logic signed [CX_W-1:0] cy    [0:CORDIC_STEPS];
  logic signed [ZW-1:0]   cz    [0:CORDIC_STEPS];
  logic [MAG_W-1:0]       plain_mag;
  logic [MAG_W-1:0]       den_mag;
  logic [MAG_W-1:0]       num_mag;

  assign plain_mag = {sq_side[ROOT_W].plain, 8'd0};
  assign den_mag   = sq_side[ROOT_W].sqrt_is_num ? plain_mag : sq_root[ROOT_W];
  assign num_mag   = sq_side[ROOT_W].sqrt_is_num ? sq_root[ROOT_W] : plain_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else begin
      cv[0] <= sq_valid[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    cside[0] <= sq_side[ROOT_W];
    cx[0]    <= signed'({4'd0, den_mag, 6'd0});
    cy[0]    <= signed'({4'd0, num_mag, 6'd0});
    cz[0]    <= '0;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [CX_W-1:0] dx;
    logic signed [CX_W-1:0] dy;
    logic signed [ZW-1:0]   da;
    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;
    assign da = signed'(ZW'(atan_rom(i)));

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else begin
        cv[i+1] <= cv[i];
      end
    end

    always_ff @(posedge clk) begin
      cside[i+1] <= cside[i];
      if (cy[i] > 0) begin
        cx[i+1] <= cx[i] + dx;
        cy[i+1] <= cy[i] - dy;
        cz[i+1] <= cz[i] + da;
      end else begin
        cx[i+1] <= cx[i] - dx;
        cy[i+1] <= cy[i] + dy;
        cz[i+1] <= cz[i] - da;
      end
    end
  end

  // clamp, truncate, apply sign; fixed results for the special cases
  side_t                fside;
  logic signed [ZW-1:0] fz;
  logic [9:0]           mag;
  logic signed [10:0]   angle_next;

  assign fside = cside[CORDIC_STEPS];
  assign fz    = cz[CORDIC_STEPS];

  always_comb begin
    if (fz < 0)
      mag = 10'd0;
    else if (fz > Z_MAX)
      mag = 10'(RIGHT_ANGLE);
    else
      mag = fz[ANGLE_SHIFT+9:ANGLE_SHIFT];
    case (fside.kind)
      K_CORDIC: angle_next = fside.neg ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
      K_POS90:  angle_next = 11'sd900;
      K_NEG90:  angle_next = -11'sd900;
      default:  angle_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cv[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    angle_tenths <= angle_next;
    degenerate   <= fside.kind == K_DEGEN;
  end

endmodule
